// ===== hw/rtl/direct_mapped_l1_cache_defines.svh =====
// Assertion macros for the direct-mapped L1 cache
`ifndef DIRECT_MAPPED_L1_CACHE_DEFINES_SVH
`define DIRECT_MAPPED_L1_CACHE_DEFINES_SVH

`ifndef SYNTH
// prop must hold at every clock edge out of reset
`define DMC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");
// cond must never be true out of reset
`define DMC_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define DMC_ASSERT(label, clk, rst_n, prop)
`define DMC_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ===== hw/rtl/dmc_pkg.sv =====
// Shared constants and types of the direct-mapped L1 cache
`timescale 1ns / 1ps

package dmc_pkg;

  localparam int unsigned MEMORY_BYTES = 65536;
  localparam int unsigned CACHE_LINES  = 256;
  localparam int unsigned BLOCK_BYTES  = 64;
  localparam int unsigned WORD_BYTES   = 4;

  localparam int unsigned BLOCK_WORDS = BLOCK_BYTES / WORD_BYTES;
  localparam int unsigned MEM_WORDS   = MEMORY_BYTES / WORD_BYTES;

  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned COST_W    = 10;
  localparam int unsigned ACC_W     = 12;
  localparam int unsigned CFG_IDX_W = 8;

  localparam int unsigned WORD_LSB = $clog2(WORD_BYTES);
  localparam int unsigned LINE_LSB = $clog2(BLOCK_BYTES);
  localparam int unsigned LINE_W   = $clog2(CACHE_LINES);
  localparam int unsigned TAG_LSB  = LINE_LSB + LINE_W;
  localparam int unsigned WORD_W   = LINE_LSB - WORD_LSB;
  localparam int unsigned TAG_W    = ADDR_W - TAG_LSB;
  localparam int unsigned DATA_AW  = LINE_W + WORD_W;
  localparam int unsigned MEM_AW   = $clog2(MEM_WORDS);
  localparam int unsigned CNT_W    = $clog2(BLOCK_WORDS + 1);

  typedef enum logic {
    ACT_READ  = 1'b0,
    ACT_WRITE = 1'b1
  } action_e;

  localparam logic [CFG_IDX_W-1:0] REG_CACHE_READ_COST  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CACHE_WRITE_COST = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MEM_READ_COST    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MEM_WRITE_COST   = CFG_IDX_W'(3);

  localparam logic [COST_W-1:0] CACHE_READ_COST_RST  = COST_W'(1);
  localparam logic [COST_W-1:0] CACHE_WRITE_COST_RST = COST_W'(1);
  localparam logic [COST_W-1:0] MEM_READ_COST_RST    = COST_W'(100);
  localparam logic [COST_W-1:0] MEM_WRITE_COST_RST   = COST_W'(50);

  typedef struct packed {
    logic [COST_W-1:0] cache_read;
    logic [COST_W-1:0] cache_write;
    logic [COST_W-1:0] mem_read;
    logic [COST_W-1:0] mem_write;
  } cost_cfg_t;

  typedef struct packed {
    logic             dirty;
    logic [TAG_W-1:0] tag;
  } tag_entry_t;

  typedef struct packed {
    logic              we;
    logic [LINE_W-1:0] addr;
    tag_entry_t        wdata;
  } tag_req_t;

  typedef struct packed {
    logic               we;
    logic [DATA_AW-1:0] addr;
    logic [DATA_W-1:0]  wdata;
  } data_req_t;

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

endpackage

// ===== hw/rtl/dmc_if.sv =====
// Handshake channel interfaces of the direct-mapped L1 cache
`timescale 1ns / 1ps

interface dmc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [dmc_pkg::ADDR_W-1:0] address;
  logic [dmc_pkg::DATA_W-1:0] write_data;

  modport source (output valid, action, address, write_data, input ready);
  modport sink (input valid, action, address, write_data, output ready);
endinterface

interface dmc_out_if;
  logic                       valid;
  logic                       ready;
  logic [dmc_pkg::DATA_W-1:0] read_data;
  logic                       was_hit;
  logic [dmc_pkg::ACC_W-1:0]  access_cost;
  logic [dmc_pkg::TIME_W-1:0] total_time;

  modport source (output valid, read_data, was_hit, access_cost, total_time, input ready);
  modport sink (input valid, read_data, was_hit, access_cost, total_time, output ready);
endinterface

interface dmc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dmc_pkg::CFG_IDX_W-1:0] index;
  logic [dmc_pkg::COST_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/direct_mapped_l1_cache.sv =====
// Top level of the direct-mapped write-back L1 cache with its backing memory
`timescale 1ns / 1ps

// Direct-mapped write-back cache of 256 lines of 64 bytes in front of a 64 KiB
// word-wide backing memory held inside the block. Each transfer on in_i is one
// word read or write; each produces exactly one transfer on out_o carrying the
// word read, the hit flag, the cost charged and the running time. After reset
// the backing memory is zeroed by a pass over its 16384 words, one word per
// cycle, during which no item is taken; cost registers are to be written
// through cfg_i only while no item is in flight, and the block itself does not
// enforce this. Throughput is set by the single-port tag, line and backing
// memories: a hit needs only the lookup, a miss on a clean or empty line adds a
// fill (16 words read from memory and written into the line), and a miss that
// evicts a dirty line first writes 16 more words back. A finished result sits
// in an output register, so the next item is taken while it waits.
module direct_mapped_l1_cache (
  input  logic      clk_i,
  input  logic      rst_ni,
  dmc_in_if.sink    in_i,
  dmc_out_if.source out_o,
  dmc_cfg_if.sink   cfg_i
);

  dmc_pkg::cost_cfg_t         cost_q;
  dmc_pkg::tag_req_t          tag_req;
  dmc_pkg::tag_entry_t        tag_rdata;
  dmc_pkg::data_req_t         data_req;
  logic [dmc_pkg::DATA_W-1:0] data_rdata;
  dmc_pkg::mem_req_t          mem_req;
  logic [dmc_pkg::DATA_W-1:0] mem_rdata;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_q.cache_read  <= dmc_pkg::CACHE_READ_COST_RST;
      cost_q.cache_write <= dmc_pkg::CACHE_WRITE_COST_RST;
      cost_q.mem_read    <= dmc_pkg::MEM_READ_COST_RST;
      cost_q.mem_write   <= dmc_pkg::MEM_WRITE_COST_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        dmc_pkg::REG_CACHE_READ_COST:  cost_q.cache_read  <= cfg_i.data;
        dmc_pkg::REG_CACHE_WRITE_COST: cost_q.cache_write <= cfg_i.data;
        dmc_pkg::REG_MEM_READ_COST:    cost_q.mem_read    <= cfg_i.data;
        dmc_pkg::REG_MEM_WRITE_COST:   cost_q.mem_write   <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  dmc_ram #(
    .DEPTH (dmc_pkg::CACHE_LINES),
    .WIDTH ($bits(dmc_pkg::tag_entry_t))
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_req.we),
    .addr_i  (tag_req.addr),
    .wdata_i (tag_req.wdata),
    .rdata_o (tag_rdata)
  );

  dmc_ram #(
    .DEPTH (dmc_pkg::CACHE_LINES * dmc_pkg::BLOCK_WORDS),
    .WIDTH (dmc_pkg::DATA_W)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_req.we),
    .addr_i  (data_req.addr),
    .wdata_i (data_req.wdata),
    .rdata_o (data_rdata)
  );

  dmc_ram #(
    .DEPTH (dmc_pkg::MEM_WORDS),
    .WIDTH (dmc_pkg::DATA_W)
  ) u_mem_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

  dmc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .out_o        (out_o),
    .cost_i       (cost_q),
    .tag_req_o    (tag_req),
    .tag_rdata_i  (tag_rdata),
    .data_req_o   (data_req),
    .data_rdata_i (data_rdata),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata)
  );

endmodule

// ===== hw/rtl/dmc_ram.sv =====
// Generic single-port synchronous RAM, read-first, registered read data
`timescale 1ns / 1ps

module dmc_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/dmc_ctrl.sv =====
// Cache controller: lookup, victim writeback, block fill, cost accounting
`timescale 1ns / 1ps
`include "direct_mapped_l1_cache_defines.svh"

module dmc_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  dmc_in_if.sink                     in_i,
  dmc_out_if.source                  out_o,
  input  dmc_pkg::cost_cfg_t         cost_i,
  output dmc_pkg::tag_req_t          tag_req_o,
  input  dmc_pkg::tag_entry_t        tag_rdata_i,
  output dmc_pkg::data_req_t         data_req_o,
  input  logic [dmc_pkg::DATA_W-1:0] data_rdata_i,
  output dmc_pkg::mem_req_t          mem_req_o,
  input  logic [dmc_pkg::DATA_W-1:0] mem_rdata_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_WB,
    ST_FILL,
    ST_FIN,
    ST_DONE
  } state_e;

  state_e                          state_q;
  logic [dmc_pkg::MEM_AW-1:0]      clr_cnt_q;
  logic [dmc_pkg::CNT_W-1:0]       cnt_q;
  logic [dmc_pkg::CACHE_LINES-1:0] valid_q;
  logic                            is_wr_q;
  logic [dmc_pkg::ADDR_W-1:0]      addr_q;
  logic [dmc_pkg::DATA_W-1:0]      wdata_q;
  logic                            hit_q;
  logic                            dirty_vic_q;
  logic [dmc_pkg::TAG_W-1:0]       vtag_q;
  logic [dmc_pkg::DATA_W-1:0]      rdata_q;

  logic                            out_valid_q;
  logic [dmc_pkg::DATA_W-1:0]      out_rdata_q;
  logic                            out_hit_q;
  logic [dmc_pkg::ACC_W-1:0]       out_cost_q;
  logic [dmc_pkg::TIME_W-1:0]      total_q;

  logic [dmc_pkg::WORD_W-1:0]      word;
  logic [dmc_pkg::LINE_W-1:0]      line;
  logic [dmc_pkg::TAG_W-1:0]       tag;
  logic [dmc_pkg::WORD_W-1:0]      in_word;
  logic [dmc_pkg::LINE_W-1:0]      in_line;
  logic [dmc_pkg::WORD_W-1:0]      cnt_idx;
  logic [dmc_pkg::WORD_W-1:0]      prev_idx;
  logic                            hit;
  logic                            vic_dirty;
  logic                            out_free;
  logic [dmc_pkg::ACC_W-1:0]       cost;
  logic [dmc_pkg::TIME_W-1:0]      total_d;

  assign word     = addr_q[dmc_pkg::LINE_LSB-1:dmc_pkg::WORD_LSB];
  assign line     = addr_q[dmc_pkg::TAG_LSB-1:dmc_pkg::LINE_LSB];
  assign tag      = addr_q[dmc_pkg::ADDR_W-1:dmc_pkg::TAG_LSB];
  assign in_word  = in_i.address[dmc_pkg::LINE_LSB-1:dmc_pkg::WORD_LSB];
  assign in_line  = in_i.address[dmc_pkg::TAG_LSB-1:dmc_pkg::LINE_LSB];
  assign cnt_idx  = cnt_q[dmc_pkg::WORD_W-1:0];
  assign prev_idx = cnt_idx - dmc_pkg::WORD_W'(1);

  assign hit       = valid_q[line] && (tag_rdata_i.tag == tag);
  assign vic_dirty = valid_q[line] && tag_rdata_i.dirty;
  assign out_free  = !out_valid_q || out_o.ready;

  always_comb begin
    cost = dmc_pkg::ACC_W'(is_wr_q ? cost_i.cache_write : cost_i.cache_read);
    if (!hit_q) begin
      cost = cost + dmc_pkg::ACC_W'(cost_i.mem_read);
      if (dirty_vic_q) begin
        cost = cost + dmc_pkg::ACC_W'(cost_i.mem_write);
      end
      if (is_wr_q) begin
        cost = cost + dmc_pkg::ACC_W'(cost_i.mem_write);
      end
    end
  end

  assign total_d = total_q + dmc_pkg::TIME_W'(cost);

  always_comb begin
    tag_req_o        = '0;
    tag_req_o.addr   = line;
    tag_req_o.wdata  = '{dirty: 1'b0, tag: tag};
    data_req_o       = '0;
    data_req_o.addr  = {line, word};
    data_req_o.wdata = wdata_q;
    mem_req_o        = '0;
    mem_req_o.addr   = dmc_pkg::MEM_AW'(addr_q[dmc_pkg::ADDR_W-1:dmc_pkg::WORD_LSB]);
    mem_req_o.wdata  = wdata_q;
    case (state_q)
      ST_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = clr_cnt_q;
        mem_req_o.wdata = '0;
      end
      ST_IDLE: begin
        tag_req_o.addr  = in_line;
        data_req_o.addr = {in_line, in_word};
      end
      ST_LOOKUP: begin
        if (hit) begin
          if (is_wr_q) begin
            data_req_o.we   = 1'b1;
            tag_req_o.we    = 1'b1;
            tag_req_o.wdata = '{dirty: 1'b1, tag: tag};
          end
        end else begin
          // prefetch first victim word for writeback
          data_req_o.addr = {line, dmc_pkg::WORD_W'(0)};
        end
      end
      ST_WB: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = dmc_pkg::MEM_AW'({vtag_q, line, cnt_idx});
        mem_req_o.wdata = data_rdata_i;
        data_req_o.addr = {line, cnt_idx + dmc_pkg::WORD_W'(1)};
      end
      ST_FILL: begin
        mem_req_o.addr   = dmc_pkg::MEM_AW'({tag, line, cnt_idx});
        data_req_o.we    = (cnt_q != '0);
        data_req_o.addr  = {line, prev_idx};
        data_req_o.wdata = mem_rdata_i;
      end
      ST_FIN: begin
        tag_req_o.we  = 1'b1;
        data_req_o.we = is_wr_q;
        mem_req_o.we  = is_wr_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      cnt_q       <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      if (out_o.ready && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + dmc_pkg::MEM_AW'(1);
          if (clr_cnt_q == dmc_pkg::MEM_AW'(dmc_pkg::MEM_WORDS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_i.valid) begin
            is_wr_q <= (in_i.action == dmc_pkg::ACT_WRITE);
            addr_q  <= in_i.address;
            wdata_q <= in_i.write_data;
            state_q <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          hit_q       <= hit;
          dirty_vic_q <= !hit && vic_dirty;
          vtag_q      <= tag_rdata_i.tag;
          rdata_q     <= data_rdata_i;
          cnt_q       <= '0;
          if (hit) begin
            state_q <= ST_DONE;
          end else if (vic_dirty) begin
            state_q <= ST_WB;
          end else begin
            state_q <= ST_FILL;
          end
        end
        ST_WB: begin
          if (cnt_q == dmc_pkg::CNT_W'(dmc_pkg::BLOCK_WORDS - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_FILL;
          end else begin
            cnt_q <= cnt_q + dmc_pkg::CNT_W'(1);
          end
        end
        ST_FILL: begin
          cnt_q <= cnt_q + dmc_pkg::CNT_W'(1);
          if (cnt_q != '0 && prev_idx == word) begin
            rdata_q <= mem_rdata_i;
          end
          if (cnt_q == dmc_pkg::CNT_W'(dmc_pkg::BLOCK_WORDS)) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          valid_q[line] <= 1'b1;
          state_q       <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_rdata_q <= is_wr_q ? '0 : rdata_q;
            out_hit_q   <= hit_q;
            out_cost_q  <= cost;
            total_q     <= total_d;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.read_data   = out_rdata_q;
  assign out_o.was_hit     = out_hit_q;
  assign out_o.access_cost = out_cost_q;
  assign out_o.total_time  = total_q;

  `DMC_ASSERT(a_hit_keeps_valid, clk_i, rst_ni, (state_q == ST_LOOKUP && hit) |=> $stable(valid_q))
  `DMC_ASSERT(a_result_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == ST_DONE))
  `DMC_ASSERT(a_time_on_result, clk_i, rst_ni, !(state_q == ST_DONE && out_free) |=> $stable(total_q))
  `DMC_ASSERT_NEVER(a_dual_write_fin, clk_i, rst_ni, data_req_o.we && mem_req_o.we && state_q != ST_FIN)

endmodule

// ===== test/testbench.sv =====
// Self-checking bench for the direct-mapped L1 cache: every result transfer checked against a predictor
`timescale 1ns / 1ps

module testbench;
  import dmc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_INDEX = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_TOP_INDEX   = '1;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              was_hit;
    logic [ACC_W-1:0]  access_cost;
    logic [TIME_W-1:0] total_time;
  } cache_response_t;

  class cache_tracker;
    bit [COST_W-1:0]  cache_read_cost;
    bit [COST_W-1:0]  cache_write_cost;
    bit [COST_W-1:0]  mem_read_cost;
    bit [COST_W-1:0]  mem_write_cost;
    bit               line_valid [CACHE_LINES];
    bit               line_dirty [CACHE_LINES];
    bit [TAG_W-1:0]   line_tag [CACHE_LINES];
    bit [DATA_W-1:0]  line_words [CACHE_LINES * BLOCK_WORDS];
    bit [DATA_W-1:0]  mem_words [MEM_WORDS];
    bit [TIME_W-1:0]  elapsed;
    cache_response_t  expected_responses [$];
    int               errors;
    int               hits;
    int               misses;
    int               evictions;
    int unsigned      peak_cost;

    function new();
      cache_read_cost  = CACHE_READ_COST_RST;
      cache_write_cost = CACHE_WRITE_COST_RST;
      mem_read_cost    = MEM_READ_COST_RST;
      mem_write_cost   = MEM_WRITE_COST_RST;
    endfunction

    function int pending();
      return expected_responses.size();
    endfunction

    function void set_cost(logic [CFG_IDX_W-1:0] idx, logic [COST_W-1:0] val);
      case (idx)
        REG_CACHE_READ_COST:  cache_read_cost = val;
        REG_CACHE_WRITE_COST: cache_write_cost = val;
        REG_MEM_READ_COST:    mem_read_cost = val;
        REG_MEM_WRITE_COST:   mem_write_cost = val;
        default: ;
      endcase
    endfunction

    function void take_access(action_e act, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wdata);
      logic [WORD_W-1:0] word;
      logic [LINE_W-1:0] line;
      logic [TAG_W-1:0]  tag;
      bit                hit;
      int unsigned       cost;
      cache_response_t   resp;
      word = addr[LINE_LSB-1:WORD_LSB];
      line = addr[TAG_LSB-1:LINE_LSB];
      tag  = addr[ADDR_W-1:TAG_LSB];
      hit  = line_valid[line] && line_tag[line] == tag;
      cost = 0;
      resp.read_data = '0;
      if (!hit) begin
        if (line_valid[line] && line_dirty[line]) begin
          for (int i = 0; i < BLOCK_WORDS; i++)
            mem_words[{line_tag[line], line, WORD_W'(i)}] = line_words[{line, WORD_W'(i)}];
          cost += mem_write_cost;
          evictions++;
        end
        for (int i = 0; i < BLOCK_WORDS; i++)
          line_words[{line, WORD_W'(i)}] = mem_words[{tag, line, WORD_W'(i)}];
        cost += mem_read_cost;
        line_valid[line] = 1'b1;
        line_dirty[line] = 1'b0;
        line_tag[line]   = tag;
        misses++;
      end else begin
        hits++;
      end
      if (act == ACT_WRITE) begin
        line_words[{line, word}] = wdata;
        if (hit) begin
          line_dirty[line] = 1'b1;
        end else begin
          mem_words[{tag, line, word}] = wdata;
          cost += mem_write_cost;
        end
        cost += cache_write_cost;
      end else begin
        resp.read_data = line_words[{line, word}];
        cost += cache_read_cost;
      end
      elapsed += cost;
      if (cost > peak_cost) peak_cost = cost;
      resp.was_hit     = hit;
      resp.access_cost = ACC_W'(cost);
      resp.total_time  = elapsed;
      expected_responses.push_back(resp);
    endfunction

    function void note_failure(string msg);
      errors++;
      if (errors <= 10) $display("%t: %s", $realtime, msg);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want)
        note_failure($sformatf("mismatch on %s: expected %h, got %h", name, want, got));
    endfunction

    function void check_response(cache_response_t got);
      cache_response_t want;
      if (expected_responses.size() == 0) begin
        note_failure($sformatf("result transfer with nothing expected: data %h cost %0d",
                               got.read_data, got.access_cost));
        return;
      end
      want = expected_responses.pop_front();
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("was_hit", 32'(want.was_hit), 32'(got.was_hit));
      compare_field("access_cost", 32'(want.access_cost), 32'(got.access_cost));
      compare_field("total_time", want.total_time, got.total_time);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  dmc_in_if  in_ch ();
  dmc_out_if out_ch ();
  dmc_cfg_if cfg_ch ();

  direct_mapped_l1_cache DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  cache_tracker board = new();
  int idle_pct = 0;
  int settings = 0;
  logic [ADDR_W-1:0] last_addr = '0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("FAIL direct_mapped_l1_cache");
    $finish;
  end

  // result side: check each transfer, stall ready in bursts
  initial begin
    int stall_left;
    cache_response_t seen;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        seen.read_data   = out_ch.read_data;
        seen.was_hit     = out_ch.was_hit;
        seen.access_cost = out_ch.access_cost;
        seen.total_time  = out_ch.total_time;
        board.check_response(seen);
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(1, 7);
      end
      out_ch.ready <= (stall_left == 0);
    end
  end

  task automatic send_access(input action_e act, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] wdata);
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.address    <= addr;
    in_ch.write_data <= wdata;
    do @(posedge clk_i); while (!in_ch.ready);
    board.take_access(act, addr, wdata);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COST_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    board.set_cost(idx, val);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_costs(input logic [COST_W-1:0] rd_hit, input logic [COST_W-1:0] wr_hit,
                             input logic [COST_W-1:0] mem_rd, input logic [COST_W-1:0] mem_wr);
    wait_idle();
    write_reg(REG_CACHE_READ_COST, rd_hit);
    write_reg(REG_CACHE_WRITE_COST, wr_hit);
    write_reg(REG_MEM_READ_COST, mem_rd);
    write_reg(REG_MEM_WRITE_COST, mem_wr);
    // unmapped indexes must not alias onto the cost registers
    write_reg(REG_SPARE_INDEX, COST_W'($urandom));
    write_reg(REG_TOP_INDEX, COST_W'($urandom));
    cfg_ch.valid <= 1'b0;
    settings++;
  endtask

  // mostly reuse of the last block or a few hot lines, so hits and dirty evictions are common
  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned roll;
    logic [ADDR_W-1:0] a;
    roll = $urandom_range(0, 99);
    a = ADDR_W'($urandom);
    if (roll < 45) begin
      a[ADDR_W-1:LINE_LSB] = last_addr[ADDR_W-1:LINE_LSB];
    end else if (roll < 80) begin
      a[TAG_LSB-1:LINE_LSB] = ($urandom_range(0, 1) ? LINE_W'(CACHE_LINES - 4) : LINE_W'(0))
                              + LINE_W'($urandom_range(0, 3));
    end
    return a;
  endfunction

  task automatic run_random(input int count, input int pct);
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    action_e act;
    idle_pct = pct;
    repeat (count) begin
      if ($urandom_range(0, 99) < pct) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      addr = pick_address();
      case ($urandom_range(0, 9))
        0: data = '0;
        1: data = '1;
        default: data = $urandom;
      endcase
      act = action_e'($urandom_range(0, 1));
      send_access(act, addr, data);
      last_addr = addr;
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.action     = ACT_READ;
    in_ch.address    = '0;
    in_ch.write_data = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset costs: empty line, hits, ignored low bits, dirty and clean victims
    send_access(ACT_READ, 16'h0000, 32'h0);
    send_access(ACT_WRITE, 16'h0004, 32'hFFFF_FFFF);
    send_access(ACT_READ, 16'h0007, 32'h0);
    send_access(ACT_READ, 16'h4004, 32'h0);
    send_access(ACT_READ, 16'h0005, 32'h0);
    send_access(ACT_WRITE, 16'hFFFC, 32'hA5A5_A5A5);
    send_access(ACT_READ, 16'hFFFF, 32'h0);
    send_access(ACT_WRITE, 16'hC000, 32'h5A5A_5A5A);
    send_access(ACT_WRITE, 16'hC03C, 32'h1234_5678);
    send_access(ACT_READ, 16'h8000, 32'h0);
    send_access(ACT_READ, 16'hC03C, 32'h0);

    // full-scale costs: write miss over a dirty victim is the costliest access
    apply_costs('1, '1, '1, '1);
    send_access(ACT_WRITE, 16'hC010, 32'hDEAD_BEEF);
    send_access(ACT_WRITE, 16'h4010, 32'h0000_0001);
    send_access(ACT_READ, 16'hC010, 32'h0);
    run_random(140, 30);

    apply_costs('0, '0, '0, '0);
    run_random(140, 0);

    apply_costs(COST_W'($urandom), COST_W'($urandom), COST_W'($urandom), COST_W'($urandom));
    run_random(140, 30);

    apply_costs('0, '1, COST_W'($urandom), '1);
    run_random(140, 50);

    apply_costs(CACHE_READ_COST_RST, CACHE_WRITE_COST_RST, MEM_READ_COST_RST,
                MEM_WRITE_COST_RST);
    run_random(140, 0);

    wait_idle();
    if (board.pending() != 0) board.note_failure("expected results left over at the end");
    $display("Covered %0d accesses: %0d hits, %0d misses, %0d dirty victims written back.",
             board.hits + board.misses, board.hits, board.misses, board.evictions);
    $display("Cost settings applied: %0d, zero and full scale among them; peak cost %0d.",
             settings, board.peak_cost);
    if (board.errors == 0) begin
      $display("PASS direct_mapped_l1_cache");
    end else begin
      $display("FAIL direct_mapped_l1_cache");
    end
    $finish;
  end

endmodule
